// ----- hdl/fac_plru_pkg.sv -----
// Shared types and constants for the fully associative pseudo-LRU cache core.
// Used by the controller, datapath, tree and top level; no dependencies.
package fac_plru_pkg;

  localparam int unsigned ADDR_IN_W = 32;
  localparam int unsigned ENTRY_W   = 9;
  localparam int unsigned COUNT_W   = 32;

  typedef struct packed {
    logic load;
    logic scan;
    logic vic_rd;
    logic vic_step;
    logic fill;
    logic mark;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic match;
    logic scan_done;
    logic full;
  } dp_sts_t;

  typedef struct packed {
    dp_sts_t dp;
    logic    leaf;
  } ctrl_sts_t;

endpackage

// ----- hdl/fac_plru_ctrl.sv -----
// Transaction sequencer: tag scan, victim walk, fill, tree update, result.
// Depends on fac_plru_pkg.
module fac_plru_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  output fac_plru_pkg::ctrl_cmd_t  cmd_o,
  input  fac_plru_pkg::ctrl_sts_t  sts_i
);
  import fac_plru_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_VRD  = 3'd2;
  localparam logic [2:0] S_VST  = 3'd3;
  localparam logic [2:0] S_FILL = 3'd4;
  localparam logic [2:0] S_MARK = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.dp.match) begin
          state_d = S_MARK;
        end else if (sts_i.dp.scan_done) begin
          state_d = sts_i.dp.full ? S_VRD : S_FILL;
        end
      end
      S_VRD: begin
        if (sts_i.leaf) begin
          state_d = S_FILL;
        end else begin
          cmd_o.vic_rd = 1'b1;
          state_d      = S_VST;
        end
      end
      S_VST: begin
        cmd_o.vic_step = 1'b1;
        state_d        = S_VRD;
      end
      S_FILL: begin
        cmd_o.fill = 1'b1;
        state_d    = S_MARK;
      end
      S_MARK: begin
        if (sts_i.leaf) begin
          state_d = S_DONE;
        end else begin
          cmd_o.mark = 1'b1;
        end
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ----- hdl/fac_plru_tree.sv -----
// Pseudo-LRU tree: hot-bit memory and a one-level-per-step walker used both
// for victim selection and for marking the used entry. Depends on fac_plru_pkg.
module fac_plru_tree #(
  parameter int unsigned ENTRIES = 512
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fac_plru_pkg::ctrl_cmd_t      cmd_i,
  input  logic [$clog2(ENTRIES)-1:0]   used_i,
  output logic [$clog2(ENTRIES)-1:0]   victim_o,
  output logic                         leaf_o
);
  import fac_plru_pkg::*;

  localparam int unsigned IDX_W  = $clog2(ENTRIES);
  localparam int unsigned NODE_W = $clog2(2 * ENTRIES);

  logic              hot_mem [2 * ENTRIES];
  logic              hot_q;
  logic [IDX_W-1:0]  lo_q, hi_q;
  logic [NODE_W-1:0] node_q;
  logic [IDX_W:0]    sum;
  logic [IDX_W-1:0]  mid;
  logic [NODE_W:0]   node_l, node_r;
  logic              mark_right;
  logic              walk_init;

  assign sum        = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid        = sum[IDX_W:1];
  assign node_l     = {node_q, 1'b0} + (NODE_W+1)'(1);
  assign node_r     = {node_q, 1'b0} + (NODE_W+1)'(2);
  assign mark_right = (used_i > mid);
  assign walk_init  = cmd_i.load | cmd_i.fill;
  assign leaf_o     = (lo_q >= hi_q);
  assign victim_o   = lo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.vic_rd) begin
      hot_q <= hot_mem[node_q];
    end
    if (cmd_i.mark) begin
      hot_mem[node_q] <= mark_right;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q   <= '0;
      hi_q   <= IDX_W'(ENTRIES - 1);
      node_q <= '0;
    end else if (walk_init) begin
      lo_q   <= '0;
      hi_q   <= IDX_W'(ENTRIES - 1);
      node_q <= '0;
    end else if (cmd_i.vic_step || cmd_i.mark) begin
      // cold side is right when the hot bit points left
      if (cmd_i.vic_step ? !hot_q : mark_right) begin
        lo_q   <= mid + IDX_W'(1);
        node_q <= node_r[NODE_W-1:0];
      end else begin
        hi_q   <= mid;
        node_q <= node_l[NODE_W-1:0];
      end
    end
  end

endmodule

// ----- hdl/fac_plru_dp.sv -----
// Datapath: tag store, sequential tag scan, fill pointer, result and counters.
// Depends on fac_plru_pkg; victim index comes from fac_plru_tree.
module fac_plru_dp #(
  parameter int unsigned ENTRIES      = 512,
  parameter int unsigned OFFSET_BITS  = 5,
  parameter int unsigned ADDRESS_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  fac_plru_pkg::ctrl_cmd_t               cmd_i,
  output fac_plru_pkg::dp_sts_t                 sts_o,
  input  logic [fac_plru_pkg::ADDR_IN_W-1:0]    byte_address_i,
  input  logic [$clog2(ENTRIES)-1:0]            victim_i,
  output logic [$clog2(ENTRIES)-1:0]            used_o,
  output logic                                  done_o,
  output logic                                  hit_o,
  output logic [fac_plru_pkg::ENTRY_W-1:0]      entry_used_o,
  output logic [fac_plru_pkg::COUNT_W-1:0]      hit_total_o,
  output logic [fac_plru_pkg::COUNT_W-1:0]      access_total_o
);
  import fac_plru_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned TAG_W = ADDRESS_BITS - OFFSET_BITS;

  logic [TAG_W-1:0]              tag_mem [ENTRIES];
  logic [ADDRESS_BITS+ADDR_IN_W-1:0] addr_ext;
  logic [TAG_W-1:0]              tag_in, tag_q, rdata_q;
  logic [IDX_W-1:0]              cmp_idx_q, used_q, scan_idx, fill_idx;
  logic [CNT_W-1:0]              scan_q, fill_q;
  logic                          cmp_vld_q, hit_q, done_q, scan_rd, full, match;
  logic [COUNT_W-1:0]            hit_cnt_q, acc_cnt_q;
  logic [IDX_W+ENTRY_W-1:0]      used_ext;

  assign addr_ext = {ADDRESS_BITS'(0), byte_address_i};
  assign tag_in   = addr_ext[ADDRESS_BITS-1:OFFSET_BITS];
  assign scan_rd  = (scan_q != fill_q);
  assign scan_idx = scan_q[IDX_W-1:0];
  assign full     = (fill_q == CNT_W'(ENTRIES));
  assign fill_idx = full ? victim_i : fill_q[IDX_W-1:0];
  assign match    = cmp_vld_q && (rdata_q == tag_q);

  assign sts_o.match     = match;
  assign sts_o.scan_done = !scan_rd && !cmp_vld_q;
  assign sts_o.full      = full;

  // tag store and payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tag_q <= tag_in;
    end
    if (cmd_i.scan && scan_rd) begin
      rdata_q   <= tag_mem[scan_idx];
      cmp_idx_q <= scan_idx;
    end
    if (cmd_i.scan && match) begin
      used_q <= cmp_idx_q;
    end
    if (cmd_i.fill) begin
      tag_mem[fill_idx] <= tag_q;
      used_q            <= fill_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
      fill_q    <= '0;
      hit_q     <= 1'b0;
      hit_cnt_q <= '0;
      acc_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.load) begin
        scan_q    <= '0;
        cmp_vld_q <= 1'b0;
        hit_q     <= 1'b0;
      end else if (cmd_i.scan) begin
        cmp_vld_q <= scan_rd;
        if (scan_rd) begin
          scan_q <= scan_q + CNT_W'(1);
        end
        if (match) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd_i.fill && !full) begin
        fill_q <= fill_q + CNT_W'(1);
      end
      if (cmd_i.finish) begin
        if (acc_cnt_q != '1) begin
          acc_cnt_q <= acc_cnt_q + COUNT_W'(1);
        end
        if (hit_q && (hit_cnt_q != '1)) begin
          hit_cnt_q <= hit_cnt_q + COUNT_W'(1);
        end
      end
    end
  end

  assign used_ext       = {{ENTRY_W{1'b0}}, used_q};
  assign used_o         = used_q;
  assign done_o         = done_q;
  assign hit_o          = hit_q;
  assign entry_used_o   = used_ext[ENTRY_W-1:0];
  assign hit_total_o    = hit_cnt_q;
  assign access_total_o = acc_cnt_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(ENTRIES))
    else $error("fill pointer beyond capacity");

  a_match_sets_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan && match |=> hit_q)
    else $error("tag match did not register a hit");

  a_fill_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fill && !full |=> fill_q == $past(fill_q) + CNT_W'(1))
    else $error("fill pointer did not advance on fill");

  a_done_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> acc_cnt_q != '0 && (hit_cnt_q <= acc_cnt_q))
    else $error("result strobe with inconsistent counters");

endmodule

// ----- hdl/fully_assoc_cache_tree_plru_core.sv -----
// Fully associative cache core with tree pseudo-LRU replacement (top level).
// One transaction in per start, one result strobe (done_o) per transaction;
// the receiver cannot stall, and done_o is high for a single cycle per result.
// A transaction scans the valid entries in order (stopping early on a hit),
// walks the tree to a victim when a miss finds the store full, fills an entry
// on any miss, updates the tree from root to leaf and registers the result;
// the tree depth is 9 at 512 entries. done_o follows in the next cycle, in
// which a new start may already be accepted. The scan is set by the single
// read port of the tag memory, which compares one stored tag per cycle. No
// clearing pass is needed after reset: the store fills in order behind a
// fill pointer.
// Depends on fac_plru_pkg, fac_plru_ctrl, fac_plru_dp and fac_plru_tree.
module fully_assoc_cache_tree_plru_core #(
  parameter int unsigned ENTRIES      = 512,
  parameter int unsigned OFFSET_BITS  = 5,
  parameter int unsigned ADDRESS_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [fac_plru_pkg::ADDR_IN_W-1:0] byte_address_i,
  output logic                               done_o,
  output logic                               hit_o,
  output logic [fac_plru_pkg::ENTRY_W-1:0]   entry_used_o,
  output logic [fac_plru_pkg::COUNT_W-1:0]   hit_total_o,
  output logic [fac_plru_pkg::COUNT_W-1:0]   access_total_o
);
  import fac_plru_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);

  ctrl_cmd_t        cmd;
  ctrl_sts_t        sts;
  dp_sts_t          dp_sts;
  logic             leaf;
  logic [IDX_W-1:0] victim, used;

  assign sts.dp   = dp_sts;
  assign sts.leaf = leaf;

  fac_plru_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  fac_plru_dp #(
    .ENTRIES      (ENTRIES),
    .OFFSET_BITS  (OFFSET_BITS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (dp_sts),
    .byte_address_i (byte_address_i),
    .victim_i       (victim),
    .used_o         (used),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .entry_used_o   (entry_used_o),
    .hit_total_o    (hit_total_o),
    .access_total_o (access_total_o)
  );

  fac_plru_tree #(
    .ENTRIES (ENTRIES)
  ) u_tree (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .used_i   (used),
    .victim_o (victim),
    .leaf_o   (leaf)
  );

endmodule
